[src/sde_pkg.sv]
// ----------------------------------------------------------------------------
// sde_pkg: shared types and constants
// Lane handshake structs, state enums and field widths for the square-root
// DPCM audio encoder.
// ----------------------------------------------------------------------------
package sde_pkg;

  localparam int SMP_W  = 16;           // PCM sample / predictor width
  localparam int ROOT_W = SMP_W + 1;    // |difference| needs one more bit
  localparam int MAG_W  = 7;            // root magnitude bits of a code
  localparam int CODE_W = MAG_W + 1;    // sign + magnitude
  localparam int SQ_W   = 2 * MAG_W;    // square of a magnitude

  localparam logic [MAG_W-1:0]  MAG_MAX  = 7'd127;
  localparam logic [ROOT_W-1:0] ROOT_TOP = 17'h10000;  // first trial bit

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_ROOT,
    LN_FIN
  } lane_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SEND
  } top_state_t;

  typedef struct packed {
    logic                    start;    // begin encoding sample
    logic                    clr_low;  // chunk boundary: clear predictor low byte
    logic signed [SMP_W-1:0] sample;
  } lane_ctrl_t;

  typedef struct packed {
    logic              busy;
    logic              done;   // one-cycle pulse, code and pred valid
    logic [CODE_W-1:0] code;
    logic [SMP_W-1:0]  pred;
  } lane_stat_t;

  typedef struct packed {
    logic load;
    logic is_header;
    logic stereo;
  } merge_req_t;

endpackage

[src/sde_lane.sv]
// ----------------------------------------------------------------------------
// sde_lane: one channel of the encoder
// Holds the channel predictor, runs a bit-pair floor square root of
// |sample - predictor| (nine steps), then clamps, squares and updates.
// ----------------------------------------------------------------------------
module sde_lane
  import sde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  output lane_stat_t stat
);

  lane_state_t       state_r, state_nxt;
  logic [SMP_W-1:0]  pred_r;
  logic [ROOT_W-1:0] v_r, res_r, bit_r;
  logic              neg_r;
  logic [CODE_W-1:0] code_r;
  logic              done_r;

  logic              root_en, fin_en;
  logic [ROOT_W-1:0] s_ext, p_ext, d_fwd, d_rev, mag;
  logic [ROOT_W:0]   trial;
  logic              take;
  logic [ROOT_W-1:0] v_nxt, res_nxt;
  logic [MAG_W-1:0]  mag_q;
  logic [SQ_W-1:0]   sq;
  logic [SMP_W-1:0]  pred_fin;

  // difference magnitude from two subtractors in parallel
  always_comb begin
    s_ext = {ctrl.sample[SMP_W-1], ctrl.sample};
    p_ext = {pred_r[SMP_W-1], pred_r};
    d_fwd = s_ext - p_ext;
    d_rev = p_ext - s_ext;
    mag   = d_fwd[ROOT_W-1] ? d_rev : d_fwd;
  end

  // one root step per cycle
  always_comb begin
    trial   = {1'b0, res_r} + {1'b0, bit_r};
    take    = ({1'b0, v_r} >= trial);
    v_nxt   = take ? (v_r - trial[ROOT_W-1:0]) : v_r;
    res_nxt = take ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  end

  // clamp, square, predictor update
  always_comb begin
    mag_q    = (|res_r[ROOT_W-1:MAG_W]) ? MAG_MAX : res_r[MAG_W-1:0];
    sq       = mag_q * mag_q;
    pred_fin = neg_r ? (pred_r - {{(SMP_W-SQ_W){1'b0}}, sq})
                     : (pred_r + {{(SMP_W-SQ_W){1'b0}}, sq});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LN_IDLE: if (ctrl.start) state_nxt = LN_ROOT;
      LN_ROOT: if (bit_r[0]) state_nxt = LN_FIN;   // last trial bit
      LN_FIN:  state_nxt = LN_IDLE;
      default: state_nxt = LN_IDLE;
    endcase
  end

  always_comb begin
    root_en = 1'b0;
    fin_en  = 1'b0;
    case (state_r)
      LN_ROOT: root_en = 1'b1;
      LN_FIN:  fin_en  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LN_IDLE;
      done_r  <= 1'b0;
      pred_r  <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= fin_en;
      if (fin_en) begin
        pred_r <= pred_fin;
      end else if (ctrl.clr_low) begin
        pred_r <= {pred_r[SMP_W-1:8], 8'h00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == LN_IDLE && ctrl.start) begin
      v_r   <= mag;
      res_r <= '0;
      bit_r <= ROOT_TOP;
      neg_r <= d_fwd[ROOT_W-1];
    end else if (root_en) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
    if (fin_en) begin
      code_r <= {neg_r, mag_q};
    end
  end

  assign stat.busy = (state_r != LN_IDLE);
  assign stat.done = done_r;
  assign stat.code = code_r;
  assign stat.pred = pred_r;

endmodule

[src/sde_merge.sv]
// ----------------------------------------------------------------------------
// sde_merge: result merge and output register
// Combines the two lane results (or the chunk flags word) into one result
// transfer and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module sde_merge
  import sde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  merge_req_t  req,
  input  lane_stat_t  lstat,
  input  lane_stat_t  rstat,
  output logic        can_load,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] left_code, [15:8] right_code, [31:16] flags_word
  output logic        out_tuser    // is_header
);

  logic              valid_r;
  logic              hdr_r;
  logic [CODE_W-1:0] lcode_r, rcode_r;
  logic [SMP_W-1:0]  flags_r;
  logic [SMP_W-1:0]  flags_w;

  assign can_load = !valid_r || out_tready;

  // stereo: both predictor high bytes; mono: whole left predictor
  assign flags_w = req.stereo ? {lstat.pred[SMP_W-1:8], rstat.pred[SMP_W-1:8]}
                              : lstat.pred;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req.load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      hdr_r   <= req.is_header;
      lcode_r <= req.is_header ? '0 : lstat.code;
      rcode_r <= (req.is_header || !req.stereo) ? '0 : rstat.code;
      flags_r <= req.is_header ? flags_w : '0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = hdr_r;
  assign out_tdata  = {flags_r, rcode_r, lcode_r};

endmodule

[src/sqrt_dpcm_audio_encoder_top.sv]
// ----------------------------------------------------------------------------
// sqrt_dpcm_audio_encoder_top: square-root DPCM audio encoder
// Encodes 16-bit PCM frames (mono or stereo) into one 8-bit code per channel,
// and returns the chunk flags word on chunk-boundary items.
// ----------------------------------------------------------------------------
// One item in, one result out. For an encode item (in_tuser = 0) the
// difference is loaded at accept, the bit-pair root iteration runs in each
// channel lane (the lanes run side by side, so stereo costs no more than
// mono), then each lane clamps, squares and updates its predictor, and the
// result is loaded into the output register. A chunk-boundary item
// (in_tuser = 1) goes straight to the output register. A finished result sits
// in the output register, so the next item is accepted while it waits; the
// block stalls only when a new result is ready and the old one is still
// untaken. Code byte: bit 7 = difference negative, bits 6..0 = floor root of
// |sample - predictor| clamped to 127. Predictors reset to zero and wrap at
// 16 bits. cfg_wr_data selects stereo (1) or mono (0); write it only while
// no item is in flight. Changing mode keeps the predictor values.
// ----------------------------------------------------------------------------
module sqrt_dpcm_audio_encoder_top
  import sde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // stereo_mode
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [15:0] left_sample, [31:16] right_sample
  input  logic        in_tuser,      // kind: 0 encode, 1 chunk boundary
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [7:0] left_code, [15:8] right_code, [31:16] flags_word
  output logic        out_tuser      // is_header
);

  top_state_t state_r, state_nxt;
  logic       stereo_r;
  logic       kind_r;
  logic       accept;
  logic       can_load;
  logic       load;

  lane_ctrl_t lctrl, rctrl;
  lane_stat_t lstat, rstat;
  merge_req_t mreq;

  // mode register: written any cycle the enable is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b0;
    end else if (cfg_wr_en) begin
      stereo_r <= cfg_wr_data;
    end
  end

  assign accept = in_tvalid && in_tready;

  // --- sequencer ---
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = in_tuser ? ST_SEND : ST_RUN;
      end
      ST_RUN: begin
        // both lanes start together, left done stands for both
        if (lstat.done) state_nxt = can_load ? ST_IDLE : ST_SEND;
      end
      ST_SEND: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load      = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_RUN:  load      = lstat.done && can_load;
      ST_SEND: load      = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) kind_r <= in_tuser;
    end
  end

  // --- lanes ---
  // stereo boundary clears both predictors' low bytes at accept
  always_comb begin
    lctrl.start   = accept && !in_tuser;
    lctrl.clr_low = accept && in_tuser && stereo_r;
    lctrl.sample  = in_tdata[15:0];
    rctrl.start   = accept && !in_tuser && stereo_r;
    rctrl.clr_low = accept && in_tuser && stereo_r;
    rctrl.sample  = in_tdata[31:16];
  end

  sde_lane u_lane_l (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (lctrl),
    .stat (lstat)
  );

  sde_lane u_lane_r (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (rctrl),
    .stat (rstat)
  );

  // --- merge / output register ---
  always_comb begin
    mreq.load      = load;
    mreq.is_header = kind_r;
    mreq.stereo    = stereo_r;
  end

  sde_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mreq),
    .lstat     (lstat),
    .rstat     (rstat),
    .can_load  (can_load),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // --- checks ---
  // lanes never run while the sequencer is idle
  a_idle_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!lstat.busy && !rstat.busy))
    else $error("lane busy while sequencer idle");

  // in stereo the right lane finishes with the left one
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && stereo_r && lstat.done) |-> rstat.done)
    else $error("right lane out of step with left lane");

  // a finished encode is either in the output register or held for it
  a_done_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && lstat.done) |=> (out_tvalid || state_r == ST_SEND))
    else $error("lane result dropped");

  // a boundary transfer goes straight to sending
  a_hdr_send: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser) |=> (state_r == ST_SEND && kind_r))
    else $error("chunk boundary not routed to output");

endmodule

[dv/sqrt_dpcm_audio_encoder_top_tb.sv]
// ----------------------------------------------------------------------------
// sqrt_dpcm_audio_encoder_top_tb: self-checking bench for the DPCM encoder
// Drives PCM frames and chunk boundaries through the input stream, predicts
// every result with a local model of both channel predictors, and compares
// each result transfer field by field. Covers mono and stereo, mode changes
// mid-stream, random idle on both sides, and a long back-pressure stretch.
// ----------------------------------------------------------------------------
module sqrt_dpcm_audio_encoder_top_tb
  import sde_pkg::*;
();

  // item kinds on in_tuser, mode values on cfg_wr_data
  localparam bit KIND_ENCODE   = 1'b0;
  localparam bit KIND_BOUNDARY = 1'b1;
  localparam bit MODE_MONO     = 1'b0;
  localparam bit MODE_STEREO   = 1'b1;

  localparam int ITEMS_PER_PHASE = 210;
  localparam int DRAIN_CYCLES    = 16;      // longer than one encode pass
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int LIMIT_CYCLES    = 500_000;

  typedef struct {
    bit                      kind;
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
  } pcm_item_t;

  typedef struct {
    bit                is_header;
    logic [CODE_W-1:0] left_code;
    logic [CODE_W-1:0] right_code;
    logic [SMP_W-1:0]  flags_word;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [15:0] left_sample, [31:16] right_sample
  logic        in_tuser;    // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [7:0] left_code, [15:8] right_code, [31:16] flags_word
  logic        out_tuser;   // is_header

  sqrt_dpcm_audio_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  pcm_item_t     pending_items[$];   // stimulus not yet offered
  frame_result_t expected_frames[$]; // predictions waiting for their transfer

  // local copy of the block's state: mode from each config write, predictors at each accepted input
  bit               stereo_shadow;
  logic [SMP_W-1:0] left_pred_shadow;
  logic [SMP_W-1:0] right_pred_shadow;

  // running waveforms the random stimulus walks along
  logic signed [SMP_W-1:0] wave_l;
  logic signed [SMP_W-1:0] wave_r;

  int  sender_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;        // receiver hold-off, counted down by the receiver
  bit  in_taken;           // input transfer at the last rising edge
  int  cycle_count;
  int  error_count;
  int  header_count;
  int  code_count;
  int  stereo_code_count;
  int  clamp_count;
  pcm_item_t drive_item;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Exact floor square root, greedy bit by bit from the top. |diff| < 2^17
  // so the root fits in 9 bits; squares are formed at 18 bits.
  function automatic logic [8:0] floor_root17(input logic [ROOT_W-1:0] mag);
    logic [8:0] root;
    logic [8:0] trial;
    root = '0;
    for (int b = 8; b >= 0; b--) begin
      trial = root | (9'd1 << b);
      if (18'(trial) * 18'(trial) <= 18'(mag))
        root = trial;
    end
    return root;
  endfunction

  // One channel: code = sign | min(root, 127); predictor moves by the
  // signed square of the magnitude, wrapping at 16 bits.
  function automatic logic [CODE_W-1:0] encode_sample(
    input logic signed [SMP_W-1:0] smp,
    inout logic [SMP_W-1:0]        pred
  );
    logic signed [SMP_W+1:0] diff;
    logic [ROOT_W-1:0]       mag;
    logic [8:0]              root;
    logic [MAG_W-1:0]        m;
    logic [SQ_W-1:0]         sq;
    diff = smp - $signed(pred);
    mag  = diff[SMP_W+1] ? ROOT_W'(-diff) : ROOT_W'(diff);
    root = floor_root17(mag);
    m    = (root > MAG_MAX) ? MAG_MAX : root[MAG_W-1:0];
    sq   = m * m;
    pred = diff[SMP_W+1] ? pred - sq : pred + sq;
    return {diff[SMP_W+1], m};
  endfunction

  function automatic frame_result_t predict_frame(input pcm_item_t itm);
    frame_result_t r;
    r = '{default: '0};
    if (itm.kind == KIND_BOUNDARY) begin
      r.is_header = 1'b1;
      if (stereo_shadow == MODE_STEREO) begin
        left_pred_shadow  &= 16'hff00;
        right_pred_shadow &= 16'hff00;
        r.flags_word = {left_pred_shadow[15:8], right_pred_shadow[15:8]};
      end else begin
        r.flags_word = left_pred_shadow;
      end
    end else begin
      r.left_code = encode_sample(itm.left, left_pred_shadow);
      if (stereo_shadow == MODE_STEREO)
        r.right_code = encode_sample(itm.right, right_pred_shadow);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly a wandering signal so the predictor tracks it and small codes
  // (exact squares included) show up; jumps and rails force the clamp.
  function automatic logic signed [SMP_W-1:0] next_sample(
    inout logic signed [SMP_W-1:0] wave
  );
    case ($urandom_range(9))
      0:       wave = 16'($urandom);
      1:       wave = 16'sh7fff;
      2:       wave = 16'sh8000;
      3, 4, 5: wave = wave + 16'($urandom_range(30) - 15);
      6, 7:    wave = wave + 16'($urandom_range(510) - 255);
      default: wave = wave + 16'($urandom_range(8190) - 4095);
    endcase
    return wave;
  endfunction

  task automatic queue_item(input bit kind, input int left, input int right);
    pcm_item_t itm;
    itm.kind  = kind;
    itm.left  = SMP_W'(left);
    itm.right = SMP_W'(right);
    pending_items.push_back(itm);
  endtask

  task automatic queue_random(input int n);
    pcm_item_t itm;
    for (int i = 0; i < n; i++) begin
      itm.kind  = ($urandom_range(99) < 8) ? KIND_BOUNDARY : KIND_ENCODE;
      itm.left  = next_sample(wave_l);
      itm.right = next_sample(wave_r);
      pending_items.push_back(itm);
    end
  endtask

  // Block is idle once everything was offered, taken and answered.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_tvalid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_idle(input int sender_pct, input int recv_pct);
    @(posedge clk);
    sender_idle_pct = sender_pct;
    recv_stall_pct  = recv_pct;
  endtask

  task automatic check_frame();
    frame_result_t exp_r;
    if (expected_frames.size() == 0) begin
      $display("%0t: unexpected result, expected none, got hdr=%0b data=%h",
               $time, out_tuser, out_tdata);
      error_count++;
      return;
    end
    exp_r = expected_frames.pop_front();
    if (out_tuser !== exp_r.is_header) begin
      $display("%0t: is_header expected %0b actual %0b",
               $time, exp_r.is_header, out_tuser);
      error_count++;
    end
    if (out_tdata[7:0] !== exp_r.left_code) begin
      $display("%0t: left_code expected %h actual %h",
               $time, exp_r.left_code, out_tdata[7:0]);
      error_count++;
    end
    if (out_tdata[15:8] !== exp_r.right_code) begin
      $display("%0t: right_code expected %h actual %h",
               $time, exp_r.right_code, out_tdata[15:8]);
      error_count++;
    end
    if (out_tdata[31:16] !== exp_r.flags_word) begin
      $display("%0t: flags_word expected %h actual %h",
               $time, exp_r.flags_word, out_tdata[31:16]);
      error_count++;
    end
    if (exp_r.is_header) begin
      header_count++;
    end else begin
      code_count++;
      if (exp_r.right_code != '0)
        stereo_code_count++;
      if (exp_r.left_code[MAG_W-1:0] == MAG_MAX || exp_r.right_code[MAG_W-1:0] == MAG_MAX)
        clamp_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: offers the head of pending_items, holds it until the transfer.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // offer stands until taken
    end else if (pending_items.size() != 0 &&
                 $urandom_range(99) >= sender_idle_pct) begin
      drive_item = pending_items.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {drive_item.right, drive_item.left};
      in_tuser  <= drive_item.kind;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when hold_cycles is set.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: mirrors the mode register, predicts on each input transfer and
  // checks each result transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, expected_frames.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        if (cfg_wr_en)
          stereo_shadow = cfg_wr_data;
        if (in_tvalid && in_tready) begin
          in_taken = 1'b1;
          expected_frames.push_back(predict_frame('{kind:  in_tuser,
                                                    left:  in_tdata[15:0],
                                                    right: in_tdata[31:16]}));
        end
        if (out_tvalid && out_tready)
          check_frame();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tuser          = 1'b0;
    out_tready        = 1'b0;
    sender_idle_pct   = 0;
    recv_stall_pct    = 0;
    hold_cycles       = 0;
    in_taken          = 1'b0;
    cycle_count       = 0;
    error_count       = 0;
    header_count      = 0;
    code_count        = 0;
    stereo_code_count = 0;
    clamp_count       = 0;
    stereo_shadow     = MODE_MONO;
    left_pred_shadow  = '0;
    right_pred_shadow = '0;
    wave_l            = '0;
    wave_r            = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, stereo. Predictors start at zero, so the first frame puts
    // one lane just past the clamp (|diff| = 16384) and the other exactly
    // on it (|diff| = 16383, root 127, negative).
    write_mode(MODE_STEREO);
    queue_item(KIND_ENCODE,   16384, -16383);
    queue_item(KIND_ENCODE,       0,      0);
    queue_item(KIND_ENCODE,   32767, -32768);  // rails, both signs
    queue_item(KIND_ENCODE,   32767, -32768);
    queue_item(KIND_BOUNDARY,     0,      0);  // low bytes cleared
    queue_item(KIND_ENCODE,  -32768,  32767);  // largest differences
    queue_item(KIND_ENCODE,      -1,      1);
    queue_item(KIND_ENCODE,      -1,      1);
    queue_item(KIND_ENCODE,       0,      0);
    queue_item(KIND_BOUNDARY,  -1,       -1);  // samples ignored on boundary
    queue_item(KIND_ENCODE,     100,   -100);
    queue_item(KIND_ENCODE,     101,    -99);
    wait_drained();

    // Directed, mono: predictors carried over, right sample ignored.
    write_mode(MODE_MONO);
    queue_item(KIND_ENCODE,     100,  12345);
    queue_item(KIND_BOUNDARY,     0,      0);  // whole left predictor
    queue_item(KIND_ENCODE,  -32768,     -1);
    queue_item(KIND_ENCODE,  -32768,  32767);
    queue_item(KIND_ENCODE,   32767, -32768);
    queue_item(KIND_BOUNDARY,     0,      0);
    queue_item(KIND_ENCODE,       7,      7);
    queue_item(KIND_BOUNDARY,     0,      0);
    wait_drained();

    // Random phases: each idle profile in both modes, mode toggled at every
    // phase so predictors cross mode changes with live values.
    for (int p = 0; p < 8; p++) begin
      write_mode((p % 2 == 0) ? MODE_STEREO : MODE_MONO);
      case (p / 2)
        0:       set_idle(0, 0);
        1:       set_idle(58, 0);
        2:       set_idle(0, 58);
        default: set_idle(24, 24);
      endcase
      queue_random(ITEMS_PER_PHASE);
      if (p == 1) begin
        // Long receiver hold-off while the sender keeps offering: the
        // output register fills, then the block stops taking input.
        repeat (40) @(posedge clk);
        hold_cycles = HOLD_OFF_CYCLES;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d code frames (%0d with a right code, %0d clamped) and %0d flag words,",
             code_count, stereo_code_count, clamp_count, header_count);
    $display("in mono and stereo, across idle, stall and hold-off phases, with %0d errors.",
             error_count);
    if (error_count == 0 && expected_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sde_pkg.sv
src/sde_lane.sv
src/sde_merge.sv
src/sqrt_dpcm_audio_encoder_top.sv
dv/sqrt_dpcm_audio_encoder_top_tb.sv
